### rtl/fbec_pkg.sv
// shared types and character mapping for the five-byte to eight-character encoder
package fbec_pkg;

    localparam int unsigned BLOCK_BYTES = 5;
    localparam int unsigned HELD_DEPTH  = 4;
    localparam int unsigned BLOCK_CHARS = 8;
    localparam int unsigned BLOCK_BITS  = 8 * BLOCK_BYTES;
    localparam int unsigned SEG_BITS    = 10;

    localparam logic [7:0] PAD_BYTE     = 8'h80;
    localparam logic [4:0] LETTER_LIMIT = 5'd25;
    localparam logic [6:0] CHAR_LOWER_A = 7'd97;
    localparam logic [6:0] DIGIT_OFFSET = 7'd22;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_END     = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] character;
        logic       last_of_group;
        logic       closing_block;
    } t_out_item;

    typedef struct packed {
        logic [BLOCK_BITS-1:0] word;
        logic                  closing;
    } t_block;

    // 0..25 -> 'a'..'z', 26..31 -> '0'..'5'
    function automatic logic [6:0] to_char(input logic [4:0] v);
        logic [6:0] r;
        if (v <= LETTER_LIMIT) begin
            r = CHAR_LOWER_A + {2'b00, v};
        end else begin
            r = DIGIT_OFFSET + {2'b00, v};
        end
        return r;
    endfunction

endpackage

### rtl/fbec_gather.sv
// byte gathering stage: holds up to four bytes and builds the 40-bit block
module fbec_gather (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  fbec_pkg::t_in_item i_data,
    output logic              o_blk_valid,
    output fbec_pkg::t_block  o_blk,
    input  logic              i_take
);
    import fbec_pkg::*;

    logic [7:0] r_held [HELD_DEPTH];
    logic [2:0] r_count;
    t_block     r_blk;
    logic       r_blk_valid;

    logic       accept;
    logic       store;
    t_block     n_blk;
    logic [7:0] blk_byte [BLOCK_BYTES];

    assign accept = i_valid && !r_blk_valid;
    assign store  = (i_data.kind == KIND_DATA) && (r_count < 3'(HELD_DEPTH));

    always_comb begin
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (k < HELD_DEPTH && 3'(k) < r_count) begin
                blk_byte[k] = r_held[k % HELD_DEPTH];
            end else if (3'(k) == r_count && i_data.kind == KIND_END) begin
                blk_byte[k] = PAD_BYTE;
            end else if (k == BLOCK_BYTES - 1 && i_data.kind == KIND_DATA) begin
                blk_byte[k] = i_data.data_byte;
            end else begin
                blk_byte[k] = 8'h00;
            end
        end
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            n_blk.word[BLOCK_BITS-1-8*k -: 8] = blk_byte[k];
        end
        n_blk.closing = (i_data.kind == KIND_END);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_blk_valid <= 1'b0;
        end else begin
            if (accept) begin
                if (store) begin
                    r_count <= r_count + 3'd1;
                end else begin
                    r_count     <= '0;
                    r_blk_valid <= 1'b1;
                end
            end else if (i_take) begin
                r_blk_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && store) begin
            r_held[r_count[1:0]] <= i_data.data_byte;
        end
        if (accept && !store) begin
            r_blk <= n_blk;
        end
    end

    assign o_stall     = r_blk_valid;
    assign o_blk_valid = r_blk_valid;
    assign o_blk       = r_blk;

endmodule

### rtl/fbec_serial.sv
// character serializer: sends one block as eight characters, one per transfer
module fbec_serial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_blk_valid,
    input  fbec_pkg::t_block   i_blk,
    output logic               o_take,
    output logic               o_valid,
    input  logic               i_stall,
    output fbec_pkg::t_out_item o_data
);
    import fbec_pkg::*;

    logic [BLOCK_BITS-1:0] r_word;
    logic                  r_closing;
    logic [2:0]            r_idx;
    logic                  r_valid;

    logic                  sent;
    logic                  last;
    logic [SEG_BITS-1:0]   seg;
    logic [4:0]            x_val;
    logic [4:0]            y_val;

    assign last   = (r_idx == 3'(BLOCK_CHARS - 1));
    assign sent   = r_valid && !i_stall;
    assign o_take = i_blk_valid && (!r_valid || (sent && last));

    // top segment: odd bits give the first character, even bits the second
    assign seg   = r_word[BLOCK_BITS-1 -: SEG_BITS];
    assign x_val = {seg[9], seg[7], seg[5], seg[3], seg[1]};
    assign y_val = {seg[8], seg[6], seg[4], seg[2], seg[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
                r_idx   <= '0;
            end else if (sent) begin
                if (last) begin
                    r_valid <= 1'b0;
                end
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word    <= i_blk.word;
            r_closing <= i_blk.closing;
        end else if (sent && r_idx[0]) begin
            r_word <= {r_word[BLOCK_BITS-SEG_BITS-1:0], {SEG_BITS{1'b0}}};
        end
    end

    assign o_valid              = r_valid;
    assign o_data.character     = to_char(r_idx[0] ? y_val : x_val);
    assign o_data.last_of_group = last;
    assign o_data.closing_block = r_closing;

endmodule

### rtl/five_byte_to_eight_char_encoder.sv
// top level of the five-byte to eight-character text encoder
// Bytes arrive one per transfer and are gathered five at a time into a 40-bit
// block, first byte most significant; each block leaves as eight printable
// characters ('a'..'z' for 0..25, '0'..'5' for 26..31), one per output
// transfer, with last_of_group set on the eighth. An end-of-stream item
// appends 0x80 after the held bytes, zero-fills the block and sends it with
// closing_block set. A data byte that does not complete a block is taken and
// produces nothing. A finished block waits in a one-block buffer while the
// previous block is still being sent, so the input side keeps running; the
// input stalls only while that buffer is occupied. The character serializer
// sets the rate and holds while i_stall is set; the completing byte is
// registered into the one-block buffer and then loaded into the serializer
// before the first character leaves.
module five_byte_to_eight_char_encoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  fbec_pkg::t_in_item  i_data,
    // character output channel
    output logic                o_valid,
    input  logic                i_stall,
    output fbec_pkg::t_out_item o_data
);
    import fbec_pkg::*;

    // finished block handed from the gathering stage to the serializer
    t_block blk;
    logic   blk_valid;
    logic   blk_take;

    // gathering stage: holding registers, byte count and the one-block buffer
    fbec_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_blk_valid (blk_valid),
        .o_blk       (blk),
        .i_take      (blk_take)
    );

    // serializer: shifts the block out ten bits per character pair
    fbec_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_blk_valid (blk_valid),
        .i_blk       (blk),
        .o_take      (blk_take),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule
